// File: src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that is also evaluated during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/pcmf_pkg.sv
package pcmf_pkg;

  // Sample format codes held in the configuration register
  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_F32 = 3'd3,
    FMT_F64 = 3'd4
  } fmt_t;

  localparam logic [2:0] FMT_RESET = FMT_S16;

  // Count leading zeros of a 32-bit word; all zeros gives 32
  function automatic logic [5:0] lzc32(input logic [31:0] x);
    logic [5:0] n;
    logic       found;
    n = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (x[i] && !found) begin
        n = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// File: src/pcm_sample_to_float32.sv
// PCM sample to float32 converter.
// Input channel: in_valid / in_stall with in_raw_sample (64 bits, right
// aligned). Output channel: out_valid / out_stall with out_float_sample, the
// IEEE single-precision bit pattern. A transaction completes on a rising edge
// where valid is high and stall is low.
// Configuration: cfg_valid / cfg_ready write channel carrying the 3-bit
// sample format (0 u8, 1 s16, 2 s32, 3 float32, 4 float64). cfg_ready is
// always high; write it only while no sample is in flight.
// Data path: input register, then one pass of conversion logic into the output
// register; out_valid rises once the sample is loaded into the output register.
// Throughput: one sample per cycle, sustained while out_stall is low.
// When the receiver stalls, the output register holds its sample and the
// input register fills; in_stall then rises combinationally from out_stall.
// Reset (rst_n low, synchronous) empties both registers and sets the format
// to signed 16-bit.
`include "assert_macros.svh"

module pcm_sample_to_float32 import pcmf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_raw_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_float_sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_sample_format
);

  logic [2:0]  fmt_r;
  logic        s1_valid_r;
  logic [63:0] s1_raw_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [31:0] res_nxt;
  logic        adv;
  logic        in_acc;

  // Handshake control
  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_float_sample = out_data_r;

  // Hold format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= cfg_sample_format;
    end
  end

  // Advance the two registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) out_valid_r <= s1_valid_r;
      if (in_acc) s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_raw_r <= in_raw_sample;
    if (adv && s1_valid_r) out_data_r <= res_nxt;
  end

  // Unsigned 8-bit: (x - 127) / 127, fraction is r repeated in 7-bit blocks
  logic signed [8:0] u8_v;
  logic [7:0]        u8_mag;
  logic              u8_q;
  logic [6:0]        u8_r;
  logic [3:0]        u8_sh;
  logic [35:0]       u8_g;
  logic [35:0]       u8_gs;
  logic [30:0]       u8_base;
  logic              u8_rnd;
  logic [31:0]       u8_res;

  always_comb begin
    u8_v   = $signed({1'b0, s1_raw_r[7:0]}) - 9'sd127;
    u8_mag = u8_v[8] ? 8'(-u8_v) : u8_v[7:0];
    u8_q   = (u8_mag >= 8'd127);
    u8_r   = u8_q ? 7'(u8_mag - 8'd127) : u8_mag[6:0];
    u8_sh  = u8_q ? 4'd0 : 4'(lzc32({u8_r, 25'b0}) + 6'd1);
    u8_g   = {u8_q, u8_r, u8_r, u8_r, u8_r, u8_r};
    u8_gs  = u8_g << u8_sh;
    u8_base = {8'(8'd127 - {4'b0, u8_sh}), u8_gs[34:12]};
    u8_rnd = u8_gs[11] && ((u8_r != 7'd0) || u8_gs[12]);
    u8_res = (u8_mag == 8'd0) ? 32'd0 : {u8_v[8], 31'(u8_base + {30'b0, u8_rnd})};
  end

  // Signed 16-bit: v / 32767, fraction is r repeated in 15-bit blocks
  logic [15:0] s16_mag;
  logic        s16_q;
  logic [14:0] s16_r;
  logic [4:0]  s16_sh;
  logic [45:0] s16_g;
  logic [45:0] s16_gs;
  logic [30:0] s16_base;
  logic        s16_rnd;
  logic [31:0] s16_res;

  always_comb begin
    s16_mag = s1_raw_r[15] ? 16'(-s1_raw_r[15:0]) : s1_raw_r[15:0];
    s16_q   = (s16_mag >= 16'd32767);
    s16_r   = s16_q ? 15'(s16_mag - 16'd32767) : s16_mag[14:0];
    s16_sh  = s16_q ? 5'd0 : 5'(lzc32({s16_r, 17'b0}) + 6'd1);
    s16_g   = {s16_q, s16_r, s16_r, s16_r};
    s16_gs  = s16_g << s16_sh;
    s16_base = {8'(8'd127 - {3'b0, s16_sh}), s16_gs[44:22]};
    s16_rnd = s16_gs[21] && ((s16_r != 15'd0) || s16_gs[22]);
    s16_res = (s16_mag == 16'd0) ? 32'd0 :
              {s1_raw_r[15], 31'(s16_base + {30'b0, s16_rnd})};
  end

  // Signed 32-bit: round to float, then scale by 2^-31
  logic [31:0] s32_mag;
  logic [5:0]  s32_lz;
  logic [31:0] s32_norm;
  logic [30:0] s32_base;
  logic        s32_rnd;
  logic [31:0] s32_res;

  always_comb begin
    s32_mag  = s1_raw_r[31] ? 32'(-s1_raw_r[31:0]) : s1_raw_r[31:0];
    s32_lz   = lzc32(s32_mag);
    s32_norm = s32_mag << s32_lz[4:0];
    s32_base = {8'(8'd127 - {2'b0, s32_lz}), s32_norm[30:8]};
    s32_rnd  = s32_norm[7] && ((|s32_norm[6:0]) || s32_norm[8]);
    s32_res  = (s32_mag == 32'd0) ? 32'd0 :
               {s1_raw_r[31], 31'(s32_base + {30'b0, s32_rnd})};
  end

  // Float64 narrowing with round to nearest even
  logic [10:0]  d_exp;
  logic [51:0]  d_man;
  logic [52:0]  d_m;
  logic         d_norm;
  logic [5:0]   d_s;
  logic [116:0] d_w;
  logic [30:0]  d_q;
  logic [30:0]  d_base;
  logic         d_rnd;
  logic [31:0]  f64_res;

  always_comb begin
    d_exp  = s1_raw_r[62:52];
    d_man  = s1_raw_r[51:0];
    d_m    = {1'b1, d_man};
    d_norm = (d_exp >= 11'd897);
    d_s    = d_norm ? 6'd29 : ((d_exp > 11'd872) ? 6'(11'd926 - d_exp) : 6'd53);
    d_w    = {d_m, 64'b0} >> d_s;
    d_q    = d_w[94:64];
    d_base = d_norm ? {8'(d_exp - 11'd896), d_q[22:0]} : d_q;
    d_rnd  = d_w[63] && ((|d_w[62:0]) || d_q[0]);
    if (d_exp == 11'h7ff) begin
      f64_res = (d_man == 52'd0) ? {s1_raw_r[63], 31'h7f800000} :
                {s1_raw_r[63], 9'h1ff, d_man[50:29]};
    end else if (d_exp >= 11'd1151) begin
      f64_res = {s1_raw_r[63], 31'h7f800000};
    end else if (d_exp <= 11'd872) begin
      f64_res = {s1_raw_r[63], 31'd0};
    end else begin
      f64_res = {s1_raw_r[63], 31'(d_base + {30'b0, d_rnd})};
    end
  end

  // Select the result for the configured format
  always_comb begin
    case (fmt_r)
      FMT_U8:  res_nxt = u8_res;
      FMT_S16: res_nxt = s16_res;
      FMT_S32: res_nxt = s32_res;
      FMT_F32: res_nxt = s1_raw_r[31:0];
      FMT_F64: res_nxt = f64_res;
      default: res_nxt = 32'd0;
    endcase
  end

  `ASSERT_CLK(a_no_drop, clk, rst_n, s1_valid_r && !adv |=> s1_valid_r, "held sample lost")
  `ASSERT_CLK(a_move, clk, rst_n, s1_valid_r && adv |=> out_valid_r, "sample not moved out")
  `ASSERT_CLK(a_f32_pass, clk, rst_n, s1_valid_r && adv && fmt_r == FMT_F32 |=> out_data_r == $past(s1_raw_r[31:0]), "float32 not passed through")
  `ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !s1_valid_r && !out_valid_r, "reset left data")

endmodule
